### src/rpa_pkg.sv
// ============================================================================
// rpa_pkg
// shared types, codes and sizes of the reference-counted page allocator
// ============================================================================
package rpa_pkg;

    // sizes
    localparam int MAX_PAGES     = 1024;
    localparam int PAGE_BITS     = $clog2(MAX_PAGES);
    localparam int DEPTH_BITS    = $clog2(MAX_PAGES + 1);
    localparam int MAX_BATCH     = 64;
    localparam int BATCH_BITS    = 7;
    localparam int COUNT_BITS    = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QFILL_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_ADDR_BITS = 2;
    localparam int APB_DATA_BITS = 32;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // register map
    localparam logic [APB_ADDR_BITS-1:0] REG_ACTIVE_PAGES = 2'd0;

    // opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RETAIN  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    // result status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_NO_PAGES = 3'd1;
    localparam logic [2:0] STS_RANGE    = 3'd2;
    localparam logic [2:0] STS_FREE     = 3'd3;
    localparam logic [2:0] STS_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] page_id;
        logic [6:0] count;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        page_valid;
        logic [9:0]  page_out;
        logic [15:0] ref_count;
        logic [10:0] pages_free;
        logic        last;
    } rsp_t;

    // class of an accepted request, decided by the front end
    typedef enum logic [2:0] {
        K_ALLOC,
        K_EMPTY,
        K_NOMEM,
        K_RANGE,
        K_RETAIN,
        K_RELEASE,
        K_QUERY
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [9:0] page_id;
        logic [6:0] count;
    } work_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_OP_WR
    } state_t;

endpackage

### src/refcounted_page_allocator.sv
// ============================================================================
// refcounted_page_allocator
// page allocator with a free-page stack and per-page reference counts
// ============================================================================
// usage
//   req channel (req_valid / req_stall / req) carries one request transaction:
//   allocate count pages, retain, release or query a page. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns the results; a granted allocate of n pages
//   gives n transactions, the final one with last set, every other request one.
//   the front end classifies requests into a two-entry queue, so requests are
//   taken while the back end works and while a result waits on rsp_stall, until it is full.
//   steps: retain, release and query pop with a count table read, then write;
//   an allocate pops, then per page reads the stack and then writes the count;
//   rejected or empty requests are popped as their result is written.
//   one request at a time; the memory read-then-write sets the rate.
//   a stalled result holds in the output register and the back end waits.
//   reset: all 1024 pages free, counts zero, lowest ids handed out first; no
//   clearing pass is needed, both memories come up usable at once.
//   a write to active_pages (apb, address 0, 0 taken as 1, clamped to 1024)
//   reinitializes all pages as free; write only while the block is idle.
// ============================================================================
module refcounted_page_allocator
(
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  rpa_pkg::req_t                       req,
    // result channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output rpa_pkg::rsp_t                       rsp,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rpa_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [rpa_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [rpa_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    localparam logic [rpa_pkg::DEPTH_BITS-1:0] PAGES_MAX =
        rpa_pkg::DEPTH_BITS'(rpa_pkg::MAX_PAGES);

    logic [rpa_pkg::DEPTH_BITS-1:0] active_reg;
    logic [rpa_pkg::DEPTH_BITS-1:0] active_next;
    logic                           init_reg;
    logic                           cfg_we;
    logic [rpa_pkg::DEPTH_BITS-1:0] wr_val;

    logic                           wq_valid;
    rpa_pkg::work_t                 wq;
    logic                           wq_pop;

    // apb: zero-wait writes, register at address 0 only
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == rpa_pkg::REG_ACTIVE_PAGES);
    assign wr_val = pwdata[rpa_pkg::DEPTH_BITS-1:0];
    assign prdata = rpa_pkg::APB_DATA_BITS'(active_reg);

    // zero taken as one page, anything above the stack size clamped
    always_comb
    begin
        active_next = active_reg;
        if (cfg_we)
        begin
            priority if (wr_val == '0)
                active_next = rpa_pkg::DEPTH_BITS'(1);
            else if (wr_val > PAGES_MAX)
                active_next = PAGES_MAX;
            else
                active_next = wr_val;
        end
    end

    // init is registered from the write, like active_reg, so the back end sees the new count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= PAGES_MAX;
            init_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            init_reg   <= cfg_we;
        end
    end

    // front end: classify and queue
    rpa_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .active_pages (active_reg),
        .wq_valid     (wq_valid),
        .wq           (wq),
        .wq_pop       (wq_pop)
    );

    // back end: stack, count table and result register
    rpa_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .active_pages (active_reg),
        .init         (init_reg),
        .wq_valid     (wq_valid),
        .wq           (wq),
        .wq_pop       (wq_pop),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp)
    );

endmodule

### src/rpa_front.sv
// ============================================================================
// rpa_front
// accepts requests, classifies them and queues them for the back end
// ============================================================================
module rpa_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  rpa_pkg::req_t                   req,
    input  logic [rpa_pkg::DEPTH_BITS-1:0]  active_pages,
    output logic                            wq_valid,
    output rpa_pkg::work_t                  wq,
    input  logic                            wq_pop
);

    rpa_pkg::work_t                     cls;
    logic                               in_range;
    logic                               push;
    rpa_pkg::work_t                     fifo_reg [rpa_pkg::QUEUE_DEPTH];
    logic [rpa_pkg::QPTR_BITS-1:0]      wr_ptr_reg;
    logic [rpa_pkg::QPTR_BITS-1:0]      wr_ptr_next;
    logic [rpa_pkg::QPTR_BITS-1:0]      rd_ptr_reg;
    logic [rpa_pkg::QPTR_BITS-1:0]      rd_ptr_next;
    logic [rpa_pkg::QFILL_BITS-1:0]     fill_reg;
    logic [rpa_pkg::QFILL_BITS-1:0]     fill_next;

    // classification
    always_comb
    begin
        in_range     = (rpa_pkg::DEPTH_BITS'(req.page_id) < active_pages);
        cls.page_id  = req.page_id;
        cls.count    = req.count;
        cls.kind     = rpa_pkg::K_RANGE;
        unique case (req.opcode)
            rpa_pkg::OP_ALLOC:
            begin
                priority if (req.count > rpa_pkg::BATCH_BITS'(rpa_pkg::MAX_BATCH))
                    cls.kind = rpa_pkg::K_NOMEM;
                else if (req.count == '0)
                    cls.kind = rpa_pkg::K_EMPTY;
                else
                    cls.kind = rpa_pkg::K_ALLOC;
            end
            rpa_pkg::OP_RETAIN:
                cls.kind = in_range ? rpa_pkg::K_RETAIN : rpa_pkg::K_RANGE;
            rpa_pkg::OP_RELEASE:
                cls.kind = in_range ? rpa_pkg::K_RELEASE : rpa_pkg::K_RANGE;
            rpa_pkg::OP_QUERY:
                cls.kind = in_range ? rpa_pkg::K_QUERY : rpa_pkg::K_RANGE;
            default:
                cls.kind = rpa_pkg::K_RANGE;
        endcase
    end

    // small queue
    assign req_stall = (fill_reg == rpa_pkg::QFILL_BITS'(rpa_pkg::QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign wq_valid  = (fill_reg != '0);
    assign wq        = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = wq_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !wq_pop)
            fill_next = fill_reg + 1'b1;
        else if (!push && wq_pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= cls;
    end

    property p_no_pop_empty;
        @(posedge clk) disable iff (!rst_n) wq_pop |-> wq_valid;
    endproperty
    a_no_pop_empty: assert property (p_no_pop_empty)
        else $error("queue popped while empty");

    property p_fill_bound;
        @(posedge clk) disable iff (!rst_n)
            fill_reg <= rpa_pkg::QFILL_BITS'(rpa_pkg::QUEUE_DEPTH);
    endproperty
    a_fill_bound: assert property (p_fill_bound)
        else $error("queue fill count out of range");

    property p_fill_track;
        @(posedge clk) disable iff (!rst_n)
            (push && !wq_pop) |=> (fill_reg == $past(fill_reg) + 1'b1);
    endproperty
    a_fill_track: assert property (p_fill_track)
        else $error("queue fill count lost a push");

endmodule

### src/rpa_back.sv
// ============================================================================
// rpa_back
// executes queued requests against the free stack and the count table
// ============================================================================
module rpa_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rpa_pkg::DEPTH_BITS-1:0]  active_pages,
    input  logic                            init,
    input  logic                            wq_valid,
    input  rpa_pkg::work_t                  wq,
    output logic                            wq_pop,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output rpa_pkg::rsp_t                   rsp
);

    localparam logic [rpa_pkg::DEPTH_BITS-1:0] ACTIVE_RESET =
        rpa_pkg::DEPTH_BITS'(rpa_pkg::MAX_PAGES);
    localparam int SUM_BITS = rpa_pkg::DEPTH_BITS + 1;

    // memories
    logic [rpa_pkg::PAGE_BITS-1:0]  stack_mem [rpa_pkg::MAX_PAGES];
    logic [rpa_pkg::COUNT_BITS-1:0] ref_mem   [rpa_pkg::MAX_PAGES];

    logic                           stack_rd_en;
    logic [rpa_pkg::PAGE_BITS-1:0]  stack_raddr;
    logic [rpa_pkg::PAGE_BITS-1:0]  stack_rdata_reg;
    logic                           stack_we;
    logic [rpa_pkg::PAGE_BITS-1:0]  stack_waddr;
    logic [rpa_pkg::PAGE_BITS-1:0]  stack_wdata;
    logic                           ref_rd_en;
    logic [rpa_pkg::PAGE_BITS-1:0]  ref_raddr;
    logic [rpa_pkg::COUNT_BITS-1:0] ref_rdata_reg;
    logic                           ref_we;
    logic [rpa_pkg::PAGE_BITS-1:0]  ref_waddr;
    logic [rpa_pkg::COUNT_BITS-1:0] ref_wdata;

    // control and working registers
    rpa_pkg::state_t                 state_reg;
    rpa_pkg::state_t                 state_next;
    rpa_pkg::work_t                  work_reg;
    rpa_pkg::work_t                  work_next;
    logic [rpa_pkg::BATCH_BITS-1:0]  remain_reg;
    logic [rpa_pkg::BATCH_BITS-1:0]  remain_next;
    logic [rpa_pkg::DEPTH_BITS-1:0]  depth_reg;
    logic [rpa_pkg::DEPTH_BITS-1:0]  depth_next;
    logic [rpa_pkg::DEPTH_BITS-1:0]  lw_reg;
    logic [rpa_pkg::DEPTH_BITS-1:0]  lw_next;
    logic                            fresh_reg;
    logic                            fresh_next;
    logic [rpa_pkg::PAGE_BITS-1:0]   fresh_page_reg;
    logic [rpa_pkg::PAGE_BITS-1:0]   fresh_page_next;
    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    rpa_pkg::rsp_t                   rsp_reg;
    rpa_pkg::rsp_t                   rsp_next;

    logic                            out_free;
    logic [rpa_pkg::DEPTH_BITS-1:0]  top_idx;
    logic [rpa_pkg::DEPTH_BITS-1:0]  fresh_diff;
    logic [rpa_pkg::PAGE_BITS-1:0]   alloc_page;
    logic [SUM_BITS-1:0]             touch_sum;
    logic                            untouched;
    logic [rpa_pkg::COUNT_BITS-1:0]  refs;
    logic [rpa_pkg::COUNT_BITS-1:0]  refs_inc;
    logic [rpa_pkg::COUNT_BITS-1:0]  refs_dec;
    logic [rpa_pkg::DEPTH_BITS-1:0]  depth_inc;

    function automatic rpa_pkg::rsp_t make_rsp(
        input logic [2:0]                     status,
        input logic                           page_valid,
        input logic [rpa_pkg::PAGE_BITS-1:0]  page,
        input logic [rpa_pkg::COUNT_BITS-1:0] ref_count,
        input logic [rpa_pkg::DEPTH_BITS-1:0] pages_free,
        input logic                           last
    );
        rpa_pkg::rsp_t r;
        r.status     = status;
        r.page_valid = page_valid;
        r.page_out   = page;
        r.ref_count  = ref_count;
        r.pages_free = pages_free;
        r.last       = last;
        return r;
    endfunction

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign top_idx    = depth_reg - 1'b1;
    assign fresh_diff = active_pages - depth_reg;
    assign alloc_page = fresh_reg ? fresh_page_reg : stack_rdata_reg;
    // pages below active_pages - lw have been handed out since init
    assign touch_sum  = SUM_BITS'(work_reg.page_id) + SUM_BITS'(lw_reg);
    assign untouched  = (touch_sum >= SUM_BITS'(active_pages));
    assign refs       = untouched ? '0 : ref_rdata_reg;
    assign refs_inc   = refs + 1'b1;
    assign refs_dec   = refs - 1'b1;
    assign depth_inc  = depth_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        work_next       = work_reg;
        remain_next     = remain_reg;
        depth_next      = depth_reg;
        lw_next         = lw_reg;
        fresh_next      = fresh_reg;
        fresh_page_next = fresh_page_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        wq_pop          = 1'b0;
        stack_rd_en     = 1'b0;
        stack_raddr     = top_idx[rpa_pkg::PAGE_BITS-1:0];
        stack_we        = 1'b0;
        stack_waddr     = depth_reg[rpa_pkg::PAGE_BITS-1:0];
        stack_wdata     = work_reg.page_id;
        ref_rd_en       = 1'b0;
        ref_raddr       = wq.page_id;
        ref_we          = 1'b0;
        ref_waddr       = work_reg.page_id;
        ref_wdata       = refs;

        unique case (state_reg)
            rpa_pkg::S_IDLE:
            begin
                if (wq_valid)
                begin
                    unique case (wq.kind)
                        rpa_pkg::K_ALLOC:
                        begin
                            if (rpa_pkg::DEPTH_BITS'(wq.count) > depth_reg)
                            begin
                                if (out_free)
                                begin
                                    wq_pop         = 1'b1;
                                    rsp_valid_next = 1'b1;
                                    rsp_next       = make_rsp(rpa_pkg::STS_NO_PAGES, 1'b0,
                                                              '0, '0, depth_reg, 1'b1);
                                end
                            end
                            else
                            begin
                                wq_pop      = 1'b1;
                                work_next   = wq;
                                remain_next = wq.count;
                                state_next  = rpa_pkg::S_ALLOC_RD;
                            end
                        end
                        rpa_pkg::K_NOMEM:
                        begin
                            if (out_free)
                            begin
                                wq_pop         = 1'b1;
                                rsp_valid_next = 1'b1;
                                rsp_next       = make_rsp(rpa_pkg::STS_NO_PAGES, 1'b0,
                                                          '0, '0, depth_reg, 1'b1);
                            end
                        end
                        rpa_pkg::K_EMPTY:
                        begin
                            if (out_free)
                            begin
                                wq_pop         = 1'b1;
                                rsp_valid_next = 1'b1;
                                rsp_next       = make_rsp(rpa_pkg::STS_OK, 1'b0,
                                                          '0, '0, depth_reg, 1'b1);
                            end
                        end
                        rpa_pkg::K_RANGE:
                        begin
                            if (out_free)
                            begin
                                wq_pop         = 1'b1;
                                rsp_valid_next = 1'b1;
                                rsp_next       = make_rsp(rpa_pkg::STS_RANGE, 1'b0,
                                                          wq.page_id, '0, depth_reg, 1'b1);
                            end
                        end
                        rpa_pkg::K_RETAIN,
                        rpa_pkg::K_RELEASE,
                        rpa_pkg::K_QUERY:
                        begin
                            wq_pop     = 1'b1;
                            work_next  = wq;
                            ref_rd_en  = 1'b1;
                            state_next = rpa_pkg::S_OP_WR;
                        end
                        default:
                        begin
                            wq_pop = 1'b1;
                        end
                    endcase
                end
            end

            rpa_pkg::S_ALLOC_RD:
            begin
                // pop: entries below the low-water mark were never written since init; their page is computed
                stack_rd_en     = 1'b1;
                depth_next      = top_idx;
                fresh_next      = (top_idx < lw_reg);
                fresh_page_next = fresh_diff[rpa_pkg::PAGE_BITS-1:0];
                if (top_idx < lw_reg)
                    lw_next = top_idx;
                state_next      = rpa_pkg::S_ALLOC_WR;
            end

            rpa_pkg::S_ALLOC_WR:
            begin
                if (out_free)
                begin
                    ref_we         = 1'b1;
                    ref_waddr      = alloc_page;
                    ref_wdata      = rpa_pkg::COUNT_BITS'(1);
                    rsp_valid_next = 1'b1;
                    rsp_next       = make_rsp(rpa_pkg::STS_OK, 1'b1, alloc_page,
                                              rpa_pkg::COUNT_BITS'(1), depth_reg,
                                              remain_reg == rpa_pkg::BATCH_BITS'(1));
                    remain_next    = remain_reg - 1'b1;
                    state_next     = (remain_reg == rpa_pkg::BATCH_BITS'(1)) ?
                                     rpa_pkg::S_IDLE : rpa_pkg::S_ALLOC_RD;
                end
            end

            rpa_pkg::S_OP_WR:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = rpa_pkg::S_IDLE;
                    priority if (work_reg.kind == rpa_pkg::K_QUERY)
                    begin
                        rsp_next = make_rsp(rpa_pkg::STS_OK, 1'b0, work_reg.page_id,
                                            refs, depth_reg, 1'b1);
                    end
                    else if (refs == '0)
                    begin
                        rsp_next = make_rsp(rpa_pkg::STS_FREE, 1'b0, work_reg.page_id,
                                            '0, depth_reg, 1'b1);
                    end
                    else if (work_reg.kind == rpa_pkg::K_RETAIN)
                    begin
                        if (refs == rpa_pkg::CNT_MAX)
                        begin
                            rsp_next = make_rsp(rpa_pkg::STS_OVERFLOW, 1'b0,
                                                work_reg.page_id, rpa_pkg::CNT_MAX,
                                                depth_reg, 1'b1);
                        end
                        else
                        begin
                            ref_we    = 1'b1;
                            ref_wdata = refs_inc;
                            rsp_next  = make_rsp(rpa_pkg::STS_OK, 1'b0, work_reg.page_id,
                                                 refs_inc, depth_reg, 1'b1);
                        end
                    end
                    else
                    begin
                        ref_we    = 1'b1;
                        ref_wdata = refs_dec;
                        if (refs_dec == '0 && depth_reg < ACTIVE_RESET)
                        begin
                            stack_we   = 1'b1;
                            depth_next = depth_inc;
                            rsp_next   = make_rsp(rpa_pkg::STS_OK, 1'b0, work_reg.page_id,
                                                  refs_dec, depth_inc, 1'b1);
                        end
                        else
                        begin
                            rsp_next   = make_rsp(rpa_pkg::STS_OK, 1'b0, work_reg.page_id,
                                                  refs_dec, depth_reg, 1'b1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = rpa_pkg::S_IDLE;
            end
        endcase

        if (init)
        begin
            depth_next = active_pages;
            lw_next    = active_pages;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpa_pkg::S_IDLE;
            depth_reg     <= ACTIVE_RESET;
            lw_reg        <= ACTIVE_RESET;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            lw_reg        <= lw_next;
            remain_reg    <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg       <= work_next;
        fresh_reg      <= fresh_next;
        fresh_page_reg <= fresh_page_next;
        rsp_reg        <= rsp_next;
    end

    // free stack
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        if (stack_rd_en)
            stack_rdata_reg <= stack_mem[stack_raddr];
    end

    // count table
    always_ff @(posedge clk)
    begin
        if (ref_we)
            ref_mem[ref_waddr] <= ref_wdata;
        if (ref_rd_en)
            ref_rdata_reg <= ref_mem[ref_raddr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    property p_depth_bound;
        @(posedge clk) disable iff (!rst_n) depth_reg <= ACTIVE_RESET;
    endproperty
    a_depth_bound: assert property (p_depth_bound)
        else $error("stack depth above page count");

    property p_low_water;
        @(posedge clk) disable iff (!rst_n) lw_reg <= depth_reg;
    endproperty
    a_low_water: assert property (p_low_water)
        else $error("low-water mark above stack depth");

    property p_pop_nonempty;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == rpa_pkg::S_ALLOC_RD) |-> (depth_reg != '0 && remain_reg != '0);
    endproperty
    a_pop_nonempty: assert property (p_pop_nonempty)
        else $error("pop from empty stack or finished batch");

    property p_alloc_wr_order;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == rpa_pkg::S_ALLOC_WR) |->
                ($past(state_reg) == rpa_pkg::S_ALLOC_RD ||
                 $past(state_reg) == rpa_pkg::S_ALLOC_WR);
    endproperty
    a_alloc_wr_order: assert property (p_alloc_wr_order)
        else $error("allocate write without a stack read");

endmodule

### tb/tb_refcounted_page_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_refcounted_page_allocator
// self-checking bench for the reference-counted page allocator: a shadow copy
// of the free stack and the count table predicts every result transaction,
// directed cases cover the corners and random traffic runs with and without idling
// ============================================================================
module tb_refcounted_page_allocator;

    // run sizing
    localparam int CLK_HALF      = 1;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int WDOG_LIMIT    = 4000;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              req_valid = 1'b0;
    logic                              req_stall;
    rpa_pkg::req_t                     req       = '0;
    logic                              rsp_valid;
    logic                              rsp_stall = 1'b0;
    rpa_pkg::rsp_t                     rsp;
    logic                              psel      = 1'b0;
    logic                              penable   = 1'b0;
    logic                              pwrite    = 1'b0;
    logic [rpa_pkg::APB_ADDR_BITS-1:0] paddr     = '0;
    logic [rpa_pkg::APB_DATA_BITS-1:0] pwdata    = '0;
    logic [rpa_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;

    // shadow state of the allocator
    logic [rpa_pkg::PAGE_BITS-1:0]  shadow_stack [rpa_pkg::MAX_PAGES];
    logic [rpa_pkg::DEPTH_BITS-1:0] shadow_depth;
    logic [rpa_pkg::COUNT_BITS-1:0] shadow_refs  [rpa_pkg::MAX_PAGES];
    logic [rpa_pkg::DEPTH_BITS-1:0] shadow_active;

    // pages currently holding a reference, used to steer stimulus
    int unsigned    held_pages [$];
    // result transactions predicted but not yet seen
    rpa_pkg::rsp_t  page_results_q [$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int mismatch_cnt = 0;
    int reqs_taken   = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int overflow_hits = 0;
    int idle_cycles  = 0;

    refcounted_page_allocator u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------------

    // every page free, counts zero, lowest id on top of the stack
    task automatic shadow_init(input int unsigned pages);
        int unsigned i;
        shadow_active = pages[rpa_pkg::DEPTH_BITS-1:0];
        for (i = 0; i < rpa_pkg::MAX_PAGES; i++)
        begin
            shadow_refs[i]  = '0;
            shadow_stack[i] = (i < pages) ? rpa_pkg::PAGE_BITS'(pages - 1 - i) : '0;
        end
        shadow_depth = pages[rpa_pkg::DEPTH_BITS-1:0];
        held_pages.delete();
    endtask

    function automatic rpa_pkg::rsp_t make_result(input logic [2:0] status,
                                                  input logic valid,
                                                  input logic [rpa_pkg::PAGE_BITS-1:0] page,
                                                  input logic [rpa_pkg::COUNT_BITS-1:0] refs,
                                                  input logic last);
        rpa_pkg::rsp_t r;
        r.status     = status;
        r.page_valid = valid;
        r.page_out   = page;
        r.ref_count  = refs;
        r.pages_free = shadow_depth;
        r.last       = last;
        return r;
    endfunction

    // append one prediction at the tail of the result queue
    task automatic add_result(input rpa_pkg::rsp_t r);
        page_results_q.insert(page_results_q.size(), r);
    endtask

    task automatic add_held(input int unsigned page);
        held_pages.insert(held_pages.size(), page);
    endtask

    task automatic drop_held(input int unsigned page);
        int  i;
        bit  found;
        found = 1'b0;
        for (i = 0; i < held_pages.size() && !found; i++)
        begin
            if (held_pages[i] == page)
            begin
                held_pages.delete(i);
                found = 1'b1;
            end
        end
    endtask

    // apply one accepted request to the shadow state and queue its results
    task automatic predict_page_op(input rpa_pkg::req_t r);
        int unsigned                    n;
        int unsigned                    i;
        logic [rpa_pkg::PAGE_BITS-1:0]  pg;
        logic [rpa_pkg::COUNT_BITS-1:0] refs;
        n = 32'(r.count);
        if (r.opcode == rpa_pkg::OP_ALLOC)
        begin
            if (n > rpa_pkg::MAX_BATCH || n > shadow_depth)
                add_result(make_result(rpa_pkg::STS_NO_PAGES, 1'b0, '0, '0, 1'b1));
            else if (n == 0)
                add_result(make_result(rpa_pkg::STS_OK, 1'b0, '0, '0, 1'b1));
            else
            begin
                for (i = 0; i < n; i++)
                begin
                    shadow_depth = shadow_depth - 1'b1;
                    pg = shadow_stack[shadow_depth[rpa_pkg::PAGE_BITS-1:0]];
                    shadow_refs[pg] = 16'd1;
                    add_held(32'(pg));
                    add_result(make_result(rpa_pkg::STS_OK, 1'b1, pg, 16'd1, i + 1 == n));
                end
            end
        end
        else if (rpa_pkg::DEPTH_BITS'(r.page_id) >= shadow_active)
            add_result(make_result(rpa_pkg::STS_RANGE, 1'b0, r.page_id, '0, 1'b1));
        else
        begin
            refs = shadow_refs[r.page_id];
            if (r.opcode == rpa_pkg::OP_QUERY)
                add_result(make_result(rpa_pkg::STS_OK, 1'b0, r.page_id, refs, 1'b1));
            else if (refs == 0)
                add_result(make_result(rpa_pkg::STS_FREE, 1'b0, r.page_id, '0, 1'b1));
            else if (r.opcode == rpa_pkg::OP_RETAIN)
            begin
                if (refs == rpa_pkg::CNT_MAX)
                begin
                    overflow_hits++;
                    add_result(make_result(rpa_pkg::STS_OVERFLOW, 1'b0, r.page_id,
                                           rpa_pkg::CNT_MAX, 1'b1));
                end
                else
                begin
                    shadow_refs[r.page_id] = refs + 1'b1;
                    add_result(make_result(rpa_pkg::STS_OK, 1'b0, r.page_id,
                                           refs + 1'b1, 1'b1));
                end
            end
            else
            begin
                // release: the page goes back on top of the stack at zero
                refs = refs - 1'b1;
                shadow_refs[r.page_id] = refs;
                if (refs == 0 && shadow_depth < rpa_pkg::MAX_PAGES)
                begin
                    shadow_stack[shadow_depth[rpa_pkg::PAGE_BITS-1:0]] = r.page_id;
                    shadow_depth = shadow_depth + 1'b1;
                    drop_held(32'(r.page_id));
                end
                add_result(make_result(rpa_pkg::STS_OK, 1'b0, r.page_id, refs, 1'b1));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_cnt++;
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // request transactions feed the shadow model, result transactions are
    // compared with the oldest prediction; values sampled here are the ones
    // from before the edge
    always @(posedge clk)
    begin
        rpa_pkg::rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                reqs_taken++;
                predict_page_op(req);
            end
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (page_results_q.size() == 0)
                    report_mismatch("result with nothing outstanding, page_out",
                                    32'(rsp.page_out), 0);
                else
                begin
                    want = page_results_q.pop_front();
                    check_field("status",     32'(rsp.status),     32'(want.status));
                    check_field("page_valid", 32'(rsp.page_valid), 32'(want.page_valid));
                    check_field("page_out",   32'(rsp.page_out),   32'(want.page_out));
                    check_field("ref_count",  32'(rsp.ref_count),  32'(want.ref_count));
                    check_field("pages_free", 32'(rsp.pages_free), 32'(want.pages_free));
                    check_field("last",       32'(rsp.last),       32'(want.last));
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // watchdog: a stretch with no transaction on any port that reaches the limit ends the run
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     page_results_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one request transaction; valid stays up into the next request unless
    // the sender decides to idle
    task automatic send_req(input rpa_pkg::req_t r);
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input int unsigned page,
                           input int unsigned cnt);
        rpa_pkg::req_t r;
        r.opcode  = op;
        r.page_id = page[rpa_pkg::PAGE_BITS-1:0];
        r.count   = cnt[rpa_pkg::BATCH_BITS-1:0];
        send_req(r);
    endtask

    // stop sending and wait until every predicted result has come back, after first
    // letting the last accepted request be predicted
    task automatic wait_results_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (page_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write of active_pages, only with the block idle
    task automatic write_active_pages(input int unsigned value);
        int unsigned eff;
        wait_results_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rpa_pkg::REG_ACTIVE_PAGES;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
        // 0 is taken as 1, anything above the table size is clamped
        eff = value & 32'h7FF;
        if (eff == 0)
            eff = 1;
        if (eff > rpa_pkg::MAX_PAGES)
            eff = rpa_pkg::MAX_PAGES;
        shadow_init(eff);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // allocate, retain, release and query on the reset state
    task automatic test_basic_ops();
        send_op(rpa_pkg::OP_QUERY,   0,    0);      // free page query reads zero
        send_op(rpa_pkg::OP_RETAIN,  0,    127);    // retain of a free page
        send_op(rpa_pkg::OP_RELEASE, 1023, 0);      // release of a free page
        send_op(rpa_pkg::OP_ALLOC,   0,    0);      // empty allocate
        send_op(rpa_pkg::OP_ALLOC,   1023, 3);      // pages 0..2
        send_op(rpa_pkg::OP_RETAIN,  1,    0);
        send_op(rpa_pkg::OP_RELEASE, 1,    0);
        send_op(rpa_pkg::OP_RELEASE, 1,    0);      // back to zero, pushed on the stack
        send_op(rpa_pkg::OP_ALLOC,   0,    1);      // same page comes back first
        send_op(rpa_pkg::OP_ALLOC,   0,    65);     // over the batch limit
        send_op(rpa_pkg::OP_ALLOC,   0,    127);
        send_op(rpa_pkg::OP_ALLOC,   0,    64);     // largest batch
        send_op(rpa_pkg::OP_QUERY,   66,   0);
        send_op(rpa_pkg::OP_RELEASE, 0,    0);
        send_op(rpa_pkg::OP_RELEASE, 2,    0);
    endtask

    // register extremes: tiny pool, zero taken as one, clamp above the size
    task automatic test_config_clamp();
        write_active_pages(4);
        send_op(rpa_pkg::OP_QUERY,   4,    0);      // first page outside the pool
        send_op(rpa_pkg::OP_RETAIN,  1023, 0);
        send_op(rpa_pkg::OP_ALLOC,   0,    5);      // more than the pool
        send_op(rpa_pkg::OP_ALLOC,   0,    4);      // whole pool
        send_op(rpa_pkg::OP_ALLOC,   0,    1);      // nothing left
        send_op(rpa_pkg::OP_RELEASE, 3,    0);
        send_op(rpa_pkg::OP_ALLOC,   0,    1);
        write_active_pages(0);
        send_op(rpa_pkg::OP_ALLOC,   0,    1);
        send_op(rpa_pkg::OP_ALLOC,   0,    1);
        send_op(rpa_pkg::OP_QUERY,   1,    0);
        write_active_pages(2047);
        send_op(rpa_pkg::OP_QUERY,   1023, 0);
        send_op(rpa_pkg::OP_ALLOC,   0,    2);
    endtask

    // mostly well-formed traffic on live pages, some noise on top
    function automatic rpa_pkg::req_t random_page_op();
        rpa_pkg::req_t r;
        int unsigned   sel;
        int unsigned   pick;
        r.opcode  = 2'($urandom_range(3));
        r.page_id = 10'($urandom_range(1023));
        r.count   = 7'($urandom_range(127));
        sel = $urandom_range(99);
        if (sel < 28)
        begin
            r.opcode = rpa_pkg::OP_ALLOC;
            pick = $urandom_range(99);
            if (pick < 80)
                r.count = 7'($urandom_range(4));
            else if (pick < 95)
                r.count = 7'($urandom_range(5, 64));
            else
                r.count = 7'($urandom_range(65, 127));
        end
        else if (sel < 88 && held_pages.size() != 0)
        begin
            r.page_id = 10'(held_pages[$urandom_range(held_pages.size() - 1)]);
            pick = $urandom_range(99);
            if (pick < 40)
                r.opcode = rpa_pkg::OP_RETAIN;
            else if (pick < 85)
                r.opcode = rpa_pkg::OP_RELEASE;
            else
                r.opcode = rpa_pkg::OP_QUERY;
        end
        else if (sel < 94)
        begin
            r.opcode  = rpa_pkg::OP_QUERY;
            r.page_id = 10'($urandom_range(32'(shadow_active) - 1));
        end
        return r;
    endfunction

    task automatic test_random_traffic(input string label, input int unsigned pages,
                                       input int unsigned n_items, input int send_idle,
                                       input int rsp_idle, input bit pause_midway);
        int unsigned i;
        write_active_pages(pages);
        $display("random traffic: %s, %0d pages", label, pages);
        idle_pct  = send_idle;
        stall_pct = rsp_idle;
        for (i = 0; i < n_items; i++)
        begin
            // sender holds off until every outstanding result is back
            if (pause_midway && i == n_items / 2)
                wait_results_drained();
            send_req(random_page_op());
        end
        wait_results_drained();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        shadow_init(rpa_pkg::MAX_PAGES);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_config_clamp();
        test_random_traffic("no idling",          1024, 75, 0,  0,  1'b0);
        test_random_traffic("sender idling",      16,   75, 53, 0,  1'b1);
        test_random_traffic("receiver stalling",  6,    75, 0,  53, 1'b0);
        test_random_traffic("both idling",        64,   75, 27, 27, 1'b0);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d results over %0d register writes",
                 reqs_taken, results_seen, cfg_writes);
        $display("count saturation hit %0d times, %0d results left over",
                 overflow_hits, page_results_q.size());
        if (mismatch_cnt == 0 && page_results_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
src/rpa_pkg.sv
src/rpa_front.sv
src/rpa_back.sv
src/refcounted_page_allocator.sv
tb/tb_refcounted_page_allocator.sv
